// ----- sv/dfq_pkg.sv -----
// types and codes shared by the duplicate-rejecting queue
package dfq_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned ENTRY_W  = KEY_W + ELEM_W;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 5;

  localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POP  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_PUSHED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_HEAD   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    file_key;
    logic [ELEM_W-1:0]   element_index;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    head_key;
    logic [ELEM_W-1:0]   head_element;
    logic [OCC_W-1:0]    occupancy;
  } out_t;

endpackage

// ----- sv/dedup_fifo_queue.sv -----
// fifo of (file key, element) reservations that rejects pairs already queued
//
// in channel (in_valid/in_ready/in_data) takes one word per request: push a
// pair, peek the head or pop the head (action code 3 acts as a peek).
// out channel (out_valid/out_ready/out_data) gives exactly one word per
// request: status, head pair (zero unless status is head), and occupancy.
// a push walks the queued entries one per cycle through the single ram read
// port looking for an equal pair; peek and pop read the head, and a push to
// an empty queue writes its pair with no search.
// the request is taken only in idle, one request at a time; in_ready is low
// while a request is in work.
// the result sits in an output register; the next request may be taken while
// it waits, and that request holds in its final step until the receiver takes
// the earlier word.
// reset clears the pointers, the count and the output valid; the entry ram is
// not cleared since only queued entries are ever used.
module dedup_fifo_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dfq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dfq_pkg::out_t out_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_HEAD   = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t                       state;
  logic [PTR_W-1:0]             head;
  logic [PTR_W-1:0]             tail;
  logic [CNT_W-1:0]             count;
  logic [PTR_W-1:0]             scan_ptr;
  logic [CNT_W-1:0]             scan_n;
  dfq_pkg::in_t                 item;
  dfq_pkg::out_t                res;

  logic                         accept;
  logic                         ram_we;
  logic [PTR_W-1:0]             ram_raddr;
  logic [dfq_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [dfq_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                         ram_re;
  logic                         match;
  logic                         scan_last;
  logic                         out_free;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign match     = (ram_rdata == {item.file_key, item.element_index});
  assign scan_last = (scan_n == count);

  // head is read on every accept; peek/pop use it, push starts its scan there
  assign ram_re    = (state == S_IDLE) || (state == S_SEARCH);
  assign ram_raddr = (state == S_IDLE) ? head : scan_ptr;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {item.file_key, item.element_index};
    if (state == S_IDLE) begin
      ram_wdata = {in_data.file_key, in_data.element_index};
      ram_we    = accept && (in_data.action == dfq_pkg::ACT_PUSH) && (count == '0);
    end else if (state == S_SEARCH) begin
      ram_we = !match && scan_last && (count != FULL_CNT);
    end
  end

  dfq_ram #(
    .WIDTH (dfq_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item     <= in_data;
            scan_ptr <= next_slot(head);
            scan_n   <= CNT_W'(1);
            res.head_key     <= '0;
            res.head_element <= '0;
            if (count == '0) begin
              if (in_data.action == dfq_pkg::ACT_PUSH) begin
                tail          <= next_slot(tail);
                count         <= CNT_W'(1);
                res.status    <= dfq_pkg::STAT_PUSHED;
                res.occupancy <= dfq_pkg::OCC_W'(1);
              end else begin
                res.status    <= dfq_pkg::STAT_EMPTY;
                res.occupancy <= dfq_pkg::OCC_W'(count);
              end
              state <= S_DONE;
            end else if (in_data.action == dfq_pkg::ACT_PUSH) begin
              res.occupancy <= dfq_pkg::OCC_W'(count);
              state         <= S_SEARCH;
            end else begin
              res.occupancy <= dfq_pkg::OCC_W'(count);
              state         <= S_HEAD;
            end
          end
        end
        S_SEARCH: begin
          // ram_rdata holds entry scan_n-1 counted from the head
          if (match) begin
            res.status <= dfq_pkg::STAT_DUP;
            state      <= S_DONE;
          end else if (scan_last) begin
            if (count == FULL_CNT) begin
              res.status <= dfq_pkg::STAT_FULL;
            end else begin
              tail          <= next_slot(tail);
              count         <= count + CNT_W'(1);
              res.status    <= dfq_pkg::STAT_PUSHED;
              res.occupancy <= dfq_pkg::OCC_W'(count + CNT_W'(1));
            end
            state <= S_DONE;
          end else begin
            scan_ptr <= next_slot(scan_ptr);
            scan_n   <= scan_n + CNT_W'(1);
          end
        end
        S_HEAD: begin
          res.status       <= dfq_pkg::STAT_HEAD;
          res.head_key     <= ram_rdata[dfq_pkg::ENTRY_W-1:dfq_pkg::ELEM_W];
          res.head_element <= ram_rdata[dfq_pkg::ELEM_W-1:0];
          if (item.action == dfq_pkg::ACT_POP) begin
            head          <= next_slot(head);
            count         <= count - CNT_W'(1);
            res.occupancy <= dfq_pkg::OCC_W'(count - CNT_W'(1));
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/dfq_ram.sv -----
// generic single-write, single-read ram with registered read data
module dfq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- verif/dedup_fifo_queue_tb.sv -----
// testbench for the duplicate-rejecting reservation queue, checked against a shadow queue
`timescale 1ns / 1ps

module dedup_fifo_queue_tb;

  localparam int DEPTH        = 16;
  localparam int LONG_HOLD    = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int FINAL_ITEMS  = 150;
  localparam int POOL_SIZE    = 20;
  localparam logic [dfq_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  dfq_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dfq_pkg::out_t out_data;

  dedup_fifo_queue #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dfq_pkg::in_t  pending_words[$];
  dfq_pkg::out_t expected_words[$];
  int   mismatches = 0;
  int   cycle_count = 0;
  bit   no_idle = 1'b0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   send_gap = 0;

  logic [dfq_pkg::KEY_W-1:0]  pool_key[POOL_SIZE];
  logic [dfq_pkg::ELEM_W-1:0] pool_elem[POOL_SIZE];

  // shadow of the queue contents
  logic [dfq_pkg::KEY_W-1:0]  shadow_keys[DEPTH];
  logic [dfq_pkg::ELEM_W-1:0] shadow_elems[DEPTH];
  int                shadow_head = 0;
  int                shadow_tail = 0;
  int                shadow_count = 0;

  function automatic dfq_pkg::out_t resolve_request(dfq_pkg::in_t w);
    dfq_pkg::out_t r;
    bit   found;
    int   p;
    r = '0;
    found = 1'b0;
    if (w.action == dfq_pkg::ACT_PUSH) begin
      p = shadow_head;
      for (int n = 0; n < shadow_count; n++) begin
        if (shadow_keys[p] == w.file_key && shadow_elems[p] == w.element_index) found = 1'b1;
        p = (p + 1) % DEPTH;
      end
      if (found) begin
        r.status = dfq_pkg::STAT_DUP;
      end else if (shadow_count >= DEPTH) begin
        r.status = dfq_pkg::STAT_FULL;
      end else begin
        shadow_keys[shadow_tail]  = w.file_key;
        shadow_elems[shadow_tail] = w.element_index;
        shadow_tail = (shadow_tail + 1) % DEPTH;
        shadow_count++;
        r.status = dfq_pkg::STAT_PUSHED;
      end
    end else if (shadow_count == 0) begin
      r.status = dfq_pkg::STAT_EMPTY;
    end else begin
      // peek, pop and the spare code all report the head
      r.status       = dfq_pkg::STAT_HEAD;
      r.head_key     = shadow_keys[shadow_head];
      r.head_element = shadow_elems[shadow_head];
      if (w.action == dfq_pkg::ACT_POP) begin
        shadow_head = (shadow_head + 1) % DEPTH;
        shadow_count--;
      end
    end
    r.occupancy = shadow_count[dfq_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_words.push_back(resolve_request(pending_words.pop_front()));
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 11) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_words[0];
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    dfq_pkg::out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, actual %p", $time, out_data);
        end else begin
          want = expected_words.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("head_key", want.head_key, out_data.head_key);
          check_field("head_element", 32'(want.head_element), 32'(out_data.head_element));
          check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_ack != hold_req) begin
        hold_ack++;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_request(input logic [dfq_pkg::ACTION_W-1:0] act,
                               input logic [dfq_pkg::KEY_W-1:0] key,
                               input logic [dfq_pkg::ELEM_W-1:0] elem);
    dfq_pkg::in_t w;
    w.action        = act;
    w.file_key      = key;
    w.element_index = elem;
    pending_words.push_back(w);
  endtask

  // mostly pairs from a small pool so duplicates are common
  task automatic queue_random_request(input int push_pct);
    logic [dfq_pkg::ACTION_W-1:0] act;
    logic [dfq_pkg::KEY_W-1:0]    key;
    logic [dfq_pkg::ELEM_W-1:0]   elem;
    int                  r;
    int                  sel;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      act = dfq_pkg::ACT_PUSH;
    end else begin
      r = $urandom_range(0, 9);
      act = (r < 6) ? dfq_pkg::ACT_POP : (r < 9) ? dfq_pkg::ACT_PEEK : ACT_SPARE;
    end
    if ($urandom_range(0, 9) < 7) begin
      sel  = $urandom_range(0, POOL_SIZE - 1);
      key  = pool_key[sel];
      elem = pool_elem[sel];
    end else begin
      key  = $urandom;
      elem = 16'($urandom_range(0, 65535));
    end
    queue_request(act, key, elem);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_words.size() != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int len;
    int pct;
    pool_key[0]  = '1;
    pool_elem[0] = '1;
    pool_key[1]  = '0;
    pool_elem[1] = '0;
    for (int i = 2; i < POOL_SIZE; i++) begin
      // some pairs share a key or an element with their neighbor
      pool_key[i]  = ($urandom_range(0, 2) == 0) ? pool_key[i-1] : $urandom;
      pool_elem[i] = ($urandom_range(0, 3) == 0) ? pool_elem[i-1] : 16'($urandom_range(0, 65535));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty queue, extremes, duplicate, then fill to full
    queue_request(dfq_pkg::ACT_POP, 32'h1234_5678, 16'hABCD);
    queue_request(dfq_pkg::ACT_PEEK, '1, '1);
    queue_request(ACT_SPARE, '0, '0);
    queue_request(dfq_pkg::ACT_PUSH, '1, '1);
    queue_request(dfq_pkg::ACT_PUSH, '0, '0);
    queue_request(dfq_pkg::ACT_PUSH, '0, '0);
    queue_request(dfq_pkg::ACT_PUSH, '1, '0);
    queue_request(dfq_pkg::ACT_PEEK, '0, '0);
    queue_request(ACT_SPARE, '1, '1);
    queue_request(dfq_pkg::ACT_POP, '0, '0);
    for (int i = 0; i < 14; i++) begin
      queue_request(dfq_pkg::ACT_PUSH, 32'h A5A5_0000 + 32'(i), 16'(i * 4099));
    end
    queue_request(dfq_pkg::ACT_PUSH, 32'h5A5A_FFFF, 16'h7777);
    // already queued while full: duplicate wins over full
    queue_request(dfq_pkg::ACT_PUSH, '1, '0);
    wait_drained();

    // receiver holds off while the sender keeps offering
    hold_req++;
    for (int i = 0; i < 40; i++) queue_random_request(70);
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(20, 90);
      case ($urandom_range(0, 2))
        0: pct = 85;
        1: pct = 50;
        default: pct = 15;
      endcase
      for (int i = 0; i < len; i++) queue_random_request(pct);
      sent += len;
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
      end else begin
        while (pending_words.size() > 4) @(negedge clk);
      end
    end
    wait_drained();

    // closing stretch at full rate
    no_idle = 1'b1;
    for (int i = 0; i < FINAL_ITEMS; i++) begin
      queue_random_request(($urandom_range(0, 1) == 0) ? 80 : 30);
    end
    wait_drained();
    repeat (DEPTH + 8) @(negedge clk);

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
